@@ src/cbsc_pkg.sv @@
package cbsc_pkg;

   localparam int NUM_CC_REGS = 4;
   localparam int CC_W        = 7;
   localparam int POS_W       = 3;
   localparam int CSR_ADDR_W  = 4;
   localparam int CSR_DATA_W  = 32;
   localparam int QUEUE_DEPTH = 2;
   localparam int THERM_MAX   = 8;

   typedef struct packed {
      logic [CC_W-1:0] controller_number;
      logic [CC_W-1:0] level_value;
   } req_type;

   typedef struct packed {
      logic serial_bit;
      logic latch_now;
   } rsp_type;

   typedef struct packed {
      logic             hit;
      logic [POS_W-1:0] pos;
      logic [7:0]       pattern;
   } cmd_type;

   typedef struct packed {
      logic    valid;
      logic    full;
      cmd_type cmd;
   } queue_status_type;

   typedef enum logic {
      BACK_IDLE,
      BACK_SHIFT
   } back_state_type;

   localparam logic [7:0] THERM_TABLE [0:THERM_MAX] = '{
      8'h00, 8'h01, 8'h03, 8'h07, 8'h0F, 8'h1F, 8'h3F, 8'h7F, 8'hFF
   };

   function automatic logic [7:0] therm_code(input logic [CC_W-1:0] lvl);
      logic [3:0] idx;
      idx = (lvl > CC_W'(THERM_MAX)) ? 4'(THERM_MAX) : lvl[3:0];
      return THERM_TABLE[idx];
   endfunction

endpackage

@@ src/cbsc_front.sv @@
module cbsc_front #(
   parameter int NUM_REGS = 4
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  cbsc_pkg::req_type                  req_data,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [cbsc_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [cbsc_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [cbsc_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                               csr_pready,
   input  logic                               q_full,
   output logic                               q_push,
   output cbsc_pkg::cmd_type                  q_cmd
);

   logic [cbsc_pkg::CC_W-1:0] cc_ff [0:cbsc_pkg::NUM_CC_REGS-1];
   logic [1:0]                csr_idx;
   logic                      csr_write;

   assign csr_idx    = csr_paddr[3:2];
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = {(cbsc_pkg::CSR_DATA_W - cbsc_pkg::CC_W)'(0), cc_ff[csr_idx]};

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < cbsc_pkg::NUM_CC_REGS; i++) begin
            cc_ff[i] <= cbsc_pkg::CC_W'(i);
         end
      end else if (csr_write) begin
         cc_ff[csr_idx] <= csr_pwdata[cbsc_pkg::CC_W-1:0];
      end
   end

   assign req_ready = !q_full;
   assign q_push    = req_valid && req_ready;

   // lowest matching position wins
   always_comb begin
      q_cmd.hit     = 1'b0;
      q_cmd.pos     = '0;
      q_cmd.pattern = cbsc_pkg::therm_code(req_data.level_value);
      for (int i = cbsc_pkg::NUM_CC_REGS - 1; i >= 0; i--) begin
         if (i < NUM_REGS && cc_ff[i] == req_data.controller_number) begin
            q_cmd.hit = 1'b1;
            q_cmd.pos = cbsc_pkg::POS_W'(i);
         end
      end
   end

endmodule

@@ src/cbsc_cmd_queue.sv @@
module cbsc_cmd_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  cbsc_pkg::cmd_type          push_cmd,
   input  logic                       pop,
   output cbsc_pkg::queue_status_type status
);

   cbsc_pkg::cmd_type entry_ff [0:cbsc_pkg::QUEUE_DEPTH-1];
   logic              wr_ptr_ff;
   logic              wr_ptr_in;
   logic              rd_ptr_ff;
   logic              rd_ptr_in;
   logic [1:0]        count_ff;
   logic [1:0]        count_in;
   logic              do_push;
   logic              do_pop;

   assign status.valid = (count_ff != 2'd0);
   assign status.full  = (count_ff == 2'(cbsc_pkg::QUEUE_DEPTH));
   assign status.cmd   = entry_ff[rd_ptr_ff];

   assign do_push = push && !status.full;
   assign do_pop  = pop && status.valid;

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

@@ src/cbsc_back.sv @@
module cbsc_back #(
   parameter int NUM_REGS = 4
) (
   input  logic                       clock,
   input  logic                       reset,
   input  cbsc_pkg::queue_status_type q_status,
   output logic                       q_pop,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output cbsc_pkg::rsp_type          rsp_data
);

   localparam int CHAIN_W = NUM_REGS * 8;
   localparam int CNT_W   = $clog2(CHAIN_W + 1);

   cbsc_pkg::back_state_type state_ff;
   cbsc_pkg::back_state_type state_in;
   logic [7:0]               store_ff [0:NUM_REGS-1];
   logic [7:0]               store_in [0:NUM_REGS-1];
   logic [CHAIN_W-1:0]       chain_ff;
   logic [CHAIN_W-1:0]       chain_load;
   logic [CNT_W-1:0]         remain_ff;
   logic                     rsp_valid_ff;
   cbsc_pkg::rsp_type        rsp_ff;
   logic                     emit;

   always_comb begin
      for (int i = 0; i < NUM_REGS; i++) begin
         if (q_status.cmd.hit && q_status.cmd.pos == cbsc_pkg::POS_W'(i)) begin
            store_in[i] = q_status.cmd.pattern;
         end else begin
            store_in[i] = store_ff[i];
         end
         chain_load[CHAIN_W-1-8*i -: 8] = store_in[i];
      end
   end

   always_comb begin
      state_in = state_ff;
      q_pop    = 1'b0;
      emit     = 1'b0;
      case (state_ff)
         cbsc_pkg::BACK_IDLE: begin
            if (q_status.valid) begin
               q_pop    = 1'b1;
               state_in = cbsc_pkg::BACK_SHIFT;
            end
         end
         cbsc_pkg::BACK_SHIFT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               emit = 1'b1;
               if (remain_ff == CNT_W'(1)) begin
                  state_in = cbsc_pkg::BACK_IDLE;
               end
            end
         end
         default: begin
            state_in = cbsc_pkg::BACK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cbsc_pkg::BACK_IDLE;
         rsp_valid_ff <= 1'b0;
         remain_ff    <= '0;
         for (int i = 0; i < NUM_REGS; i++) begin
            store_ff[i] <= 8'h00;
         end
      end else begin
         state_ff <= state_in;
         if (q_pop) begin
            for (int i = 0; i < NUM_REGS; i++) begin
               store_ff[i] <= store_in[i];
            end
            remain_ff <= CNT_W'(CHAIN_W);
         end else if (emit) begin
            remain_ff <= remain_ff - CNT_W'(1);
         end
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         chain_ff <= chain_load;
      end else if (emit) begin
         chain_ff <= chain_ff << 1;
      end
      if (emit) begin
         rsp_ff.serial_bit <= chain_ff[CHAIN_W-1];
         rsp_ff.latch_now  <= (remain_ff == CNT_W'(1));
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTH
   a_shift_has_bits: assert property (@(posedge clock) disable iff (reset)
      state_ff == cbsc_pkg::BACK_SHIFT |-> remain_ff != '0)
      else $error("shifting with no bits left");

   a_pop_loads_count: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> remain_ff == CNT_W'(CHAIN_W) && state_ff == cbsc_pkg::BACK_SHIFT)
      else $error("chain not loaded after pop");

   a_latch_ends_shift: assert property (@(posedge clock) disable iff (reset)
      emit && remain_ff == CNT_W'(1) |=> rsp_valid_ff && rsp_ff.latch_now
                                          && state_ff == cbsc_pkg::BACK_IDLE)
      else $error("latch bit not last");
`endif

endmodule

@@ src/cc_bargraph_shift_chain.sv @@
// path of an item: queue entry, chain load on pop, then the registered output bit
// one-bit-per-cycle chain shifter, which stalls while rsp_valid waits on rsp_ready
// a two-entry command queue lets up to two further items be taken while a chain shifts
// reset (synchronous, active high): patterns cleared, controller numbers 0..3, queue empty
module cc_bargraph_shift_chain #(
   parameter int NUM_REGS = 4
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  cbsc_pkg::req_type               req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output cbsc_pkg::rsp_type               rsp_data,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [cbsc_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [cbsc_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [cbsc_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready
);

   logic                       q_push;
   logic                       q_pop;
   cbsc_pkg::cmd_type          q_cmd;
   cbsc_pkg::queue_status_type q_status;

   cbsc_front #(
      .NUM_REGS(NUM_REGS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .q_full      (q_status.full),
      .q_push      (q_push),
      .q_cmd       (q_cmd)
   );

   cbsc_cmd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (q_cmd),
      .pop      (q_pop),
      .status   (q_status)
   );

   cbsc_back #(
      .NUM_REGS(NUM_REGS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_status  (q_status),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
